/* rtl/differential_pressure_compensation_assert.svh */
// ============================================================================
// Assertion macros for the differential pressure compensation block
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ============================================================================
`ifndef DIFFERENTIAL_PRESSURE_COMPENSATION_ASSERT_SVH
`define DIFFERENTIAL_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define DPC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define DPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPC_ASSERT_IMPL(lbl, ante, cons, msg)
`define DPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/dpc_pkg.sv */
// ============================================================================
// dpc_pkg
// Widths, shift amounts, limits and shared types of the pressure compensator.
// ============================================================================
package dpc_pkg;

    // Field widths
    localparam int RAW_W  = 24;
    localparam int COEF_W = 16;
    localparam int PSI_W  = 24;
    localparam int PA_W   = 40;
    localparam int TEMP_W = 20;

    // Pipeline depth, input register to output register
    localparam int N_STG = 8;

    // Shift amounts of the compensation formulae
    localparam int SH_TREF     = 7;
    localparam int SH_TEMPSENS = 22;
    localparam int SH_OFF_T1   = 17;
    localparam int SH_TCO      = 5;
    localparam int SH_SENS_T1  = 16;
    localparam int SH_TCS      = 6;
    localparam int SH_PROD     = 21;
    localparam int SH_P        = 15;

    // Temperature base (20.00 degC) and pascal scale (Q16 per 0.0001 psi)
    localparam logic signed [TEMP_W:0] TEMP_BASE    = 21'sd2000;
    localparam logic [COEF_W-1:0]      PA_PER_PSIE4 = 16'd45186;

    // Temperature limits
    localparam logic signed [TEMP_W-1:0] T_MIN = -20'sd129070;
    localparam logic signed [TEMP_W-1:0] T_MAX = 20'sd264140;

    // Register indexes
    typedef enum logic [2:0] {
        REG_C1_SENS_T1  = 3'd0,
        REG_C2_OFF_T1   = 3'd1,
        REG_C3_TCS      = 3'd2,
        REG_C4_TCO      = 3'd3,
        REG_C5_TREF     = 3'd4,
        REG_C6_TEMPSENS = 3'd5
    } cfg_index_t;

    localparam logic [2:0] REG_LAST = REG_C6_TEMPSENS;

    // Calibration words as seen by the datapath
    typedef struct packed {
        logic [COEF_W-1:0] c1_sens_t1;
        logic [COEF_W-1:0] c2_off_t1;
        logic [COEF_W-1:0] c3_tcs;
        logic [COEF_W-1:0] c4_tco;
        logic [COEF_W-1:0] c5_tref;
        logic [COEF_W-1:0] c6_tempsens;
    } coeff_t;

endpackage

/* rtl/dpc_cfg_regs.sv */
// ============================================================================
// dpc_cfg_regs
// Calibration register file: six 16-bit words, write only, cleared at reset.
// ============================================================================
`include "differential_pressure_compensation_assert.svh"

module dpc_cfg_regs
    import dpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [COEF_W-1:0] cfg_data,
    output coeff_t            coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    // Decode the write; drop indexes past the last register
    always_comb
    begin
        coeff_next = coeff_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_C1_SENS_T1:  coeff_next.c1_sens_t1  = cfg_data;
                REG_C2_OFF_T1:   coeff_next.c2_off_t1   = cfg_data;
                REG_C3_TCS:      coeff_next.c3_tcs      = cfg_data;
                REG_C4_TCO:      coeff_next.c4_tco      = cfg_data;
                REG_C5_TREF:     coeff_next.c5_tref     = cfg_data;
                REG_C6_TEMPSENS: coeff_next.c6_tempsens = cfg_data;
                default:         coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= '0;
        end
        else
        begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

    // A write past the register list leaves every word untouched
    `DPC_ASSERT_NEXT(a_cfg_ignore, cfg_we && (cfg_index > REG_LAST), $stable(coeff_reg), "cfg: out-of-range write changed a register")

endmodule

/* rtl/differential_pressure_compensation.sv */
// ============================================================================
// differential_pressure_compensation
// First-order temperature compensation of a raw pressure/temperature pair.
// ============================================================================
// Usage:
//   Input stream s_axis carries one raw pressure count and one raw
//   temperature count per beat. Output stream m_axis returns, per input
//   beat, the compensated pressure in 0.0001 psi, the same pressure in
//   pascals (Q16) and the temperature in 0.01 degC.
//   Calibration words are written through cfg_we/cfg_index/cfg_data while
//   the stream is idle; indexes 0..5 select c1..c6, others are ignored.
// Pipeline and throughput:
//   Eight register stages, s1 to s8; a beat moves through them in order
//   and is presented on m_axis from the s8 output register. One beat is
//   taken every cycle unless the output is stalled; the depth is set by
//   the split 24x38 pressure product and the truncating shifts around it.
// Reset:
//   rst_n clears the calibration words to zero and empties the pipeline.
// Stall:
//   While a result waits with m_axis_tready low, the whole pipeline holds
//   and s_axis_tready is low; nothing is lost or repeated.
// ============================================================================
`include "differential_pressure_compensation_assert.svh"

module differential_pressure_compensation
    import dpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Calibration write port
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [COEF_W-1:0] cfg_data,
    // Raw sample stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
    // Compensated result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [87:0]       m_axis_tdata    // pressure_psi_e4[23:0], pressure_pa_q16[63:24],
                                              // temperature_centi[83:64], zero pad[87:84]
);

    // Internal widths
    localparam int DT_W   = RAW_W + 1;            // dT, signed
    localparam int MUL_W  = DT_W + COEF_W + 1;    // dT times a coefficient
    localparam int OS_W   = 38;                   // offset and sensitivity
    localparam int LO_W   = 19;                   // low part of sensitivity
    localparam int HI_W   = OS_W - LO_W;
    localparam int PPL_W  = RAW_W + LO_W;
    localparam int PPH_W  = RAW_W + 1 + HI_W;
    localparam int PRD_W  = 63;
    localparam int Q_W    = PRD_W - SH_PROD;
    localparam int DF_W   = Q_W + 1;
    localparam int PR_W   = DF_W - SH_P;
    localparam int PAM_W  = PSI_W + COEF_W + 1;

    localparam logic signed [MUL_W-1:0] BIAS_T = (MUL_W'(1) <<< SH_TEMPSENS) - MUL_W'(1);
    localparam logic signed [MUL_W-1:0] BIAS_O = (MUL_W'(1) <<< SH_TCO) - MUL_W'(1);
    localparam logic signed [MUL_W-1:0] BIAS_S = (MUL_W'(1) <<< SH_TCS) - MUL_W'(1);
    localparam logic signed [MUL_W-1:0] BIAS_NONE = '0;

    coeff_t coeff;

    dpc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeff     (coeff)
    );

    // ------------------------------------------------------------------
    // Pipeline control: one enable for all stages
    // ------------------------------------------------------------------
    logic             adv;
    logic [N_STG-1:0] vld_reg;
    logic [N_STG-1:0] vld_next;

    assign adv           = !vld_reg[N_STG-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[N_STG-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[N_STG-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - (c5 << 7)
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s1_reg, d1_s1_next;
    logic signed [DT_W-1:0]  dt_s1_reg, dt_s1_next;

    always_comb
    begin
        d1_s1_next = s_axis_tdata[RAW_W-1:0];
        dt_s1_next = $signed({1'b0, s_axis_tdata[2*RAW_W-1:RAW_W]})
                   - $signed({2'b00, coeff.c5_tref, {SH_TREF{1'b0}}});
    end

    // ------------------------------------------------------------------
    // Stage 2: the three dT products
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s2_reg, d1_s2_next;
    logic signed [MUL_W-1:0] mt_s2_reg, mt_s2_next;
    logic signed [MUL_W-1:0] mo_s2_reg, mo_s2_next;
    logic signed [MUL_W-1:0] ms_s2_reg, ms_s2_next;

    always_comb
    begin
        d1_s2_next = d1_s1_reg;
        mt_s2_next = dt_s1_reg * $signed({1'b0, coeff.c6_tempsens});
        mo_s2_next = dt_s1_reg * $signed({1'b0, coeff.c4_tco});
        ms_s2_next = dt_s1_reg * $signed({1'b0, coeff.c3_tcs});
    end

    // ------------------------------------------------------------------
    // Stage 3: truncating shifts, TEMP, OFF and SENS
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] d1_s3_reg, d1_s3_next;
    logic signed [TEMP_W:0]  tmp_s3_reg, tmp_s3_next;
    logic signed [OS_W-1:0]  off_s3_reg, off_s3_next;
    logic signed [OS_W-1:0]  sen_s3_reg, sen_s3_next;

    logic signed [MUL_W-1:0] mt_q, mo_q, ms_q;

    always_comb
    begin
        mt_q = (mt_s2_reg + (mt_s2_reg[MUL_W-1] ? BIAS_T : BIAS_NONE)) >>> SH_TEMPSENS;
        mo_q = (mo_s2_reg + (mo_s2_reg[MUL_W-1] ? BIAS_O : BIAS_NONE)) >>> SH_TCO;
        ms_q = (ms_s2_reg + (ms_s2_reg[MUL_W-1] ? BIAS_S : BIAS_NONE)) >>> SH_TCS;

        d1_s3_next  = d1_s2_reg;
        tmp_s3_next = $signed(mt_q[TEMP_W:0]) + TEMP_BASE;
        off_s3_next = $signed({{(OS_W-COEF_W-SH_OFF_T1){1'b0}}, coeff.c2_off_t1,
                               {SH_OFF_T1{1'b0}}})
                    + $signed(mo_q[OS_W-1:0]);
        sen_s3_next = $signed({{(OS_W-COEF_W-SH_SENS_T1){1'b0}}, coeff.c1_sens_t1,
                               {SH_SENS_T1{1'b0}}})
                    + $signed(ms_q[OS_W-1:0]);
    end

    // ------------------------------------------------------------------
    // Stage 4: D1 x SENS as two partial products; clamp TEMP
    // ------------------------------------------------------------------
    logic        [PPL_W-1:0]  ppl_s4_reg, ppl_s4_next;
    logic signed [PPH_W-1:0]  pph_s4_reg, pph_s4_next;
    logic signed [OS_W-1:0]   off_s4_reg, off_s4_next;
    logic signed [TEMP_W-1:0] tmp_s4_reg, tmp_s4_next;

    always_comb
    begin
        ppl_s4_next = PPL_W'(d1_s3_reg) * PPL_W'(sen_s3_reg[LO_W-1:0]);
        pph_s4_next = $signed({1'b0, d1_s3_reg}) * $signed(sen_s3_reg[OS_W-1:LO_W]);
        off_s4_next = off_s3_reg;
        if (tmp_s3_reg < T_MIN)
        begin
            tmp_s4_next = T_MIN;
        end
        else if (tmp_s3_reg > T_MAX)
        begin
            tmp_s4_next = T_MAX;
        end
        else
        begin
            tmp_s4_next = tmp_s3_reg[TEMP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: combine the partial products
    // ------------------------------------------------------------------
    logic signed [PRD_W-1:0]  prd_s5_reg, prd_s5_next;
    logic signed [OS_W-1:0]   off_s5_reg, off_s5_next;
    logic signed [TEMP_W-1:0] tmp_s5_reg, tmp_s5_next;

    always_comb
    begin
        prd_s5_next = (PRD_W'(pph_s4_reg) <<< LO_W)
                    + $signed({{(PRD_W-PPL_W){1'b0}}, ppl_s4_reg});
        off_s5_next = off_s4_reg;
        tmp_s5_next = tmp_s4_reg;
    end

    // ------------------------------------------------------------------
    // Stage 6: product / 2^21, toward zero
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0]    q_s6_reg, q_s6_next;
    logic signed [OS_W-1:0]   off_s6_reg, off_s6_next;
    logic signed [TEMP_W-1:0] tmp_s6_reg, tmp_s6_next;

    always_comb
    begin
        q_s6_next = $signed(prd_s5_reg[PRD_W-1:SH_PROD])
                  + $signed({{(Q_W-1){1'b0}},
                             prd_s5_reg[PRD_W-1] && (|prd_s5_reg[SH_PROD-1:0])});
        off_s6_next = off_s5_reg;
        tmp_s6_next = tmp_s5_reg;
    end

    // ------------------------------------------------------------------
    // Stage 7: (q - OFF) / 2^15 toward zero, saturate to 24 bits
    // ------------------------------------------------------------------
    logic signed [PSI_W-1:0]  psi_s7_reg, psi_s7_next;
    logic signed [TEMP_W-1:0] tmp_s7_reg, tmp_s7_next;

    logic signed [DF_W-1:0] diff;
    logic signed [PR_W-1:0] p_raw;

    always_comb
    begin
        diff  = DF_W'(q_s6_reg) - DF_W'(off_s6_reg);
        p_raw = $signed(diff[DF_W-1:SH_P])
              + $signed({{(PR_W-1){1'b0}}, diff[DF_W-1] && (|diff[SH_P-1:0])});
        if (p_raw[PR_W-1:PSI_W-1] == {(PR_W-PSI_W+1){p_raw[PSI_W-1]}})
        begin
            psi_s7_next = p_raw[PSI_W-1:0];
        end
        else
        begin
            psi_s7_next = {p_raw[PR_W-1], {(PSI_W-1){!p_raw[PR_W-1]}}};
        end
        tmp_s7_next = tmp_s6_reg;
    end

    // ------------------------------------------------------------------
    // Stage 8: pascal scaling; output register
    // ------------------------------------------------------------------
    logic signed [PSI_W-1:0]  psi_s8_reg, psi_s8_next;
    logic signed [PA_W-1:0]   pa_s8_reg, pa_s8_next;
    logic signed [TEMP_W-1:0] tmp_s8_reg, tmp_s8_next;

    logic signed [PAM_W-1:0] pa_full;

    always_comb
    begin
        pa_full     = psi_s7_reg * $signed({1'b0, PA_PER_PSIE4});
        pa_s8_next  = pa_full[PA_W-1:0];
        psi_s8_next = psi_s7_reg;
        tmp_s8_next = tmp_s7_reg;
    end

    // ------------------------------------------------------------------
    // Payload registers: advance together, hold on stall
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_s1_reg  <= d1_s1_next;
            dt_s1_reg  <= dt_s1_next;
            d1_s2_reg  <= d1_s2_next;
            mt_s2_reg  <= mt_s2_next;
            mo_s2_reg  <= mo_s2_next;
            ms_s2_reg  <= ms_s2_next;
            d1_s3_reg  <= d1_s3_next;
            tmp_s3_reg <= tmp_s3_next;
            off_s3_reg <= off_s3_next;
            sen_s3_reg <= sen_s3_next;
            ppl_s4_reg <= ppl_s4_next;
            pph_s4_reg <= pph_s4_next;
            off_s4_reg <= off_s4_next;
            tmp_s4_reg <= tmp_s4_next;
            prd_s5_reg <= prd_s5_next;
            off_s5_reg <= off_s5_next;
            tmp_s5_reg <= tmp_s5_next;
            q_s6_reg   <= q_s6_next;
            off_s6_reg <= off_s6_next;
            tmp_s6_reg <= tmp_s6_next;
            psi_s7_reg <= psi_s7_next;
            tmp_s7_reg <= tmp_s7_next;
            psi_s8_reg <= psi_s8_next;
            pa_s8_reg  <= pa_s8_next;
            tmp_s8_reg <= tmp_s8_next;
        end
    end

    assign m_axis_tdata = {4'b0000, tmp_s8_reg, pa_s8_reg, psi_s8_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `DPC_ASSERT_NEXT(a_stall_hold, !adv, $stable(vld_reg), "pipeline moved while stalled")
    `DPC_ASSERT_NEXT(a_advance, adv && vld_reg[0], vld_reg[1], "beat lost between stages")
    `DPC_ASSERT_IMPL(a_temp_range, m_axis_tvalid, (tmp_s8_reg >= T_MIN) && (tmp_s8_reg <= T_MAX), "temperature out of range")
    `DPC_ASSERT_IMPL(a_pa_sign, m_axis_tvalid, pa_s8_reg[PA_W-1] == psi_s8_reg[PSI_W-1], "pascal sign differs from psi sign")

endmodule

/* tb/differential_pressure_compensation_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// differential_pressure_compensation_tb
// Streams raw pressure/temperature pairs through the compensator under a
// series of calibration settings, with random gaps and back-pressure on
// both sides. Each beat taken is run through a local first-order
// compensation model, and each result beat is checked field by field
// against the oldest prediction.
// ============================================================================
module differential_pressure_compensation_tb;
    import dpc_pkg::*;

    localparam longint PSI_MIN = -64'sd8388608;
    localparam longint PSI_MAX = 64'sd8388607;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    // Indexes past the last calibration word; writes there must be dropped
    localparam logic [2:0] REG_SPARE_LO = REG_LAST + 3'd1;
    localparam logic [2:0] REG_SPARE_HI = REG_LAST + 3'd2;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_SAMPLES = 152;
    localparam int BACKLOG_CYCLES = 48;

    typedef struct packed {
        logic signed [PSI_W-1:0]  psi_e4;
        logic signed [PA_W-1:0]   pa_q16;
        logic signed [TEMP_W-1:0] temp_centi;
    } comp_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata;   // raw_pressure[23:0], raw_temperature[47:24]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [87:0]       m_axis_tdata;   // pressure_psi_e4[23:0], pressure_pa_q16[63:24],
                                       // temperature_centi[83:64], zero pad[87:84]

    coeff_t       cal = '0;            // calibration words as last written
    logic         calm = 1'b0;         // no idling on either side
    logic [47:0]  samples_pending[$];
    comp_result_t expected_results[$];
    comp_result_t seen_result;
    comp_result_t want_result;
    int           mismatches = 0;
    int           results_out = 0;
    int           src_gap;
    int           sink_gap;
    int           backlog_hold;
    logic         backlog_done;
    int           quiet_cycles = 0;

    differential_pressure_compensation u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // First-order compensation; all divisions truncate toward zero
    function automatic comp_result_t compensate(input logic [RAW_W-1:0] d1_raw,
                                                input logic [RAW_W-1:0] d2_raw,
                                                input coeff_t k);
        longint d1, dt, temp, off, sens, p, pa;
        comp_result_t r;
        d1   = longint'(d1_raw);
        dt   = longint'(d2_raw) - (longint'(k.c5_tref) <<< SH_TREF);
        temp = longint'(TEMP_BASE)
             + (dt * longint'(k.c6_tempsens)) / (longint'(1) <<< SH_TEMPSENS);
        off  = (longint'(k.c2_off_t1) <<< SH_OFF_T1)
             + (longint'(k.c4_tco) * dt) / (longint'(1) <<< SH_TCO);
        sens = (longint'(k.c1_sens_t1) <<< SH_SENS_T1)
             + (longint'(k.c3_tcs) * dt) / (longint'(1) <<< SH_TCS);
        p    = ((d1 * sens) / (longint'(1) <<< SH_PROD) - off) / (longint'(1) <<< SH_P);
        // Saturate both to their field ranges; pascals follow the clamped value
        if (p < PSI_MIN)
            p = PSI_MIN;
        else if (p > PSI_MAX)
            p = PSI_MAX;
        if (temp < longint'(T_MIN))
            temp = longint'(T_MIN);
        else if (temp > longint'(T_MAX))
            temp = longint'(T_MAX);
        pa = p * longint'(PA_PER_PSIE4);
        r.psi_e4     = p[PSI_W-1:0];
        r.pa_q16     = pa[PA_W-1:0];
        r.temp_centi = temp[TEMP_W-1:0];
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COEF_MAX;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_pressure();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RAW_MAX;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // Mostly close to the reference temperature, as a real sensor reads
    function automatic logic [RAW_W-1:0] pick_temperature(input longint tref);
        longint v;
        case ($urandom_range(0, 5))
            0: return RAW_W'($urandom);
            1: return $urandom_range(0, 1) ? RAW_MAX : '0;
            default:
            begin
                v = tref + longint'($urandom_range(0, 1 << 21)) - (longint'(1) << 20);
                if (v < 0)
                    v = 0;
                else if (v > longint'(RAW_MAX))
                    v = longint'(RAW_MAX);
                return v[RAW_W-1:0];
            end
        endcase
    endfunction

    task automatic queue_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        samples_pending.push_back({d2, d1});
    endtask

    // One register write, then track it in the local calibration copy
    task automatic write_coeff(input logic [2:0] idx, input logic [COEF_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_C1_SENS_T1:  cal.c1_sens_t1  = val;
            REG_C2_OFF_T1:   cal.c2_off_t1   = val;
            REG_C3_TCS:      cal.c3_tcs      = val;
            REG_C4_TCO:      cal.c4_tco      = val;
            REG_C5_TREF:     cal.c5_tref     = val;
            REG_C6_TEMPSENS: cal.c6_tempsens = val;
            default:         ;
        endcase
    endtask

    task automatic load_calibration(input coeff_t k);
        write_coeff(REG_C1_SENS_T1, k.c1_sens_t1);
        write_coeff(REG_C2_OFF_T1, k.c2_off_t1);
        write_coeff(REG_C3_TCS, k.c3_tcs);
        write_coeff(REG_C4_TCO, k.c4_tco);
        write_coeff(REG_C5_TREF, k.c5_tref);
        write_coeff(REG_C6_TEMPSENS, k.c6_tempsens);
    endtask

    // Wait for every queued sample to come back, then let the pipeline drain;
    // look at the falling edge so that the clocked blocks have all settled
    task automatic settle();
        while (samples_pending.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (N_STG + 2) @(posedge clk);
    endtask

    // Sender: offer queued samples, predict each beat taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(compensate(s_axis_tdata[23:0],
                                                      s_axis_tdata[47:24], cal));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(0, 4);
                    s_axis_tvalid <= 1'b0;
                end
                else if (samples_pending.size() != 0)
                begin
                    s_axis_tdata  <= samples_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each result beat, apply back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
            backlog_hold = 0;
            backlog_done = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result.psi_e4     = m_axis_tdata[23:0];
                seen_result.pa_q16     = m_axis_tdata[63:24];
                seen_result.temp_centi = m_axis_tdata[83:64];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat %0d: psi %0d pa %0d temp %0d",
                                 results_out, seen_result.psi_e4, seen_result.pa_q16,
                                 seen_result.temp_centi);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    if (seen_result.psi_e4 !== want_result.psi_e4
                        || seen_result.pa_q16 !== want_result.pa_q16
                        || seen_result.temp_centi !== want_result.temp_centi)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: beat %0d exp psi %0d pa %0d temp %0d, got %0d %0d %0d",
                                     results_out, want_result.psi_e4, want_result.pa_q16,
                                     want_result.temp_centi, seen_result.psi_e4,
                                     seen_result.pa_q16, seen_result.temp_centi);
                    end
                end
                results_out++;
            end
            // Hold off once for a long stretch while the sender keeps pushing
            if (!backlog_done && results_out > 200 && samples_pending.size() > 40)
            begin
                backlog_hold = BACKLOG_CYCLES;
                backlog_done = 1'b1;
            end
            if (backlog_hold > 0)
            begin
                backlog_hold--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        coeff_t k;
        longint tref;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // All calibration words still zero from reset
        queue_sample('0, '0);
        queue_sample(RAW_MAX, RAW_MAX);
        settle();

        // Every word at full scale; temperature at, just below and above Tref
        k = '1;
        load_calibration(k);
        queue_sample('0, '0);
        queue_sample(RAW_MAX, '0);
        queue_sample('0, RAW_MAX);
        queue_sample(RAW_MAX, RAW_MAX);
        queue_sample(RAW_MAX, 24'd8388480);
        queue_sample(RAW_MAX, 24'd8388479);
        queue_sample(RAW_MAX, 24'd8388481);
        settle();

        // Negative sensitivity: no base term; far below Tref, and one sample above it
        k.c1_sens_t1 = '0;
        k.c4_tco     = '0;
        load_calibration(k);
        queue_sample(RAW_MAX, '0);
        queue_sample(RAW_MAX, 24'd1);
        queue_sample('0, '0);
        queue_sample(24'd1, RAW_MAX);
        settle();

        // Tref of zero: largest dT, temperature at its upper limit
        k = '1;
        k.c5_tref = '0;
        load_calibration(k);
        queue_sample(RAW_MAX, RAW_MAX);
        queue_sample(24'h800000, 24'h800000);
        queue_sample(24'd1, 24'd1);
        settle();

        // Writes past the last register must leave the words untouched
        k.c1_sens_t1  = 16'd36402;
        k.c2_off_t1   = 16'd39473;
        k.c3_tcs      = 16'd23137;
        k.c4_tco      = 16'd23282;
        k.c5_tref     = 16'd33050;
        k.c6_tempsens = 16'd23148;
        load_calibration(k);
        write_coeff(REG_SPARE_LO, COEF_MAX);
        write_coeff(REG_SPARE_HI, COEF_MAX);
        queue_sample(24'd6465444, 24'd8077636);
        queue_sample(24'd4311346, 24'd4229342);
        settle();

        // Random calibration per phase, random samples within it
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES - 1)
                calm <= 1'b1;
            k.c1_sens_t1  = pick_coeff();
            k.c2_off_t1   = pick_coeff();
            k.c3_tcs      = pick_coeff();
            k.c4_tco      = pick_coeff();
            k.c5_tref     = pick_coeff();
            k.c6_tempsens = pick_coeff();
            load_calibration(k);
            if ($urandom_range(0, 2) == 0)
                write_coeff($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                            COEF_W'($urandom));
            tref = longint'(k.c5_tref) <<< SH_TREF;
            for (int n = 0; n < PHASE_SAMPLES; n++)
                queue_sample(pick_pressure(), pick_temperature(tref));
            settle();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
